// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: sorted priority queue shared types
// Request and status codes, cell commands and the entry record that moves
// between neighboring cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int COUNT_OUT_W   = 4;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

endpackage

// ===== sv/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue, highest first
//
//  channel | dir | tdata                                  | tuser
//  s       | in  | in_value[31:0] in_priority[63:32]      | req_type[1:0]
//  m       | out | out_value[31:0] entry_count[35:32]     | status[1:0]
//          |     | is_empty[36] (pad to 40)               |
//
// One request per cycle unless the result word stalls; the result follows in the cycle after accept.
// Each insert or remove is one compare-and-shift step across the row of cells.
// A stalled result word holds; a new request is taken as it drains.
// Reset empties the queue; stored payload is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // in_value, in_priority
    input  logic [1:0]  i_s_tuser,  // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // out_value, entry_count, is_empty
    output logic [1:0]  o_m_tuser   // status
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                     w_fire;
    t_req                     w_req;
    t_entry                   w_new;
    t_cell_op                 w_op;
    logic                     w_full;
    logic                     w_empty;
    t_entry                   w_entry [DEPTH];
    logic                     w_keep  [DEPTH];
    logic [DEPTH-1:0]         w_valid;
    logic [31:0]              w_count_ext;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic signed [DATA_W-1:0] n_out_value;
    t_status                  r_out_status;
    t_status                  n_out_status;
    logic [COUNT_OUT_W-1:0]   r_out_count;
    logic [COUNT_OUT_W-1:0]   n_out_count;
    logic                     r_out_empty;
    logic                     n_out_empty;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign w_req      = t_req'(i_s_tuser);
    assign w_new      = '{valid: 1'b1, value: i_s_tdata[31:0], prio: i_s_tdata[63:32]};
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_keep;
            if (g == 0) begin : g_head
                assign w_left      = '0;
                assign w_left_keep = 1'b1;
            end else begin : g_mid
                assign w_left      = w_entry[g-1];
                assign w_left_keep = w_keep[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (w_op),
                .i_new       (w_new),
                .i_left      (w_left),
                .i_left_keep (w_left_keep),
                .i_right     (w_right),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    always_comb begin
        w_op         = OP_HOLD;
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = ST_OK;
        if (w_fire) begin
            unique case (w_req)
                REQ_INSERT: begin
                    if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_op    = OP_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_REMOVE, REQ_PEEK: begin
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_value = w_entry[0].value;
                        if (w_req == REQ_REMOVE) begin
                            w_op    = OP_SHIFT;
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                REQ_QUERY: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign w_count_ext = 32'(n_count);
    assign n_out_count = w_count_ext[COUNT_OUT_W-1:0];
    assign n_out_empty = (n_count == '0);
    assign n_out_valid = w_fire || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_empty  <= n_out_empty;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_empty, r_out_count, r_out_value};
    assign o_m_tuser  = r_out_status;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    a_valid_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_head_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty == !w_valid[0])
        else $error("front cell validity disagrees with count");

    a_remove_dec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_req == REQ_REMOVE && !w_empty |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not lower count");

    a_insert_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_req == REQ_INSERT && w_full |=> $stable(w_valid) && r_out_status == ST_FULL)
        else $error("insert into full queue changed contents");

endmodule

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on shift it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cell_op i_op,
    input  spq_pkg::t_entry   i_new,
    input  spq_pkg::t_entry   i_left,
    input  logic              i_left_keep,
    input  spq_pkg::t_entry   i_right,
    output spq_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import spq_pkg::*;

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_prio;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;
    logic signed [DATA_W-1:0] n_prio;

    // entry stays ahead of an equal or lower new priority
    assign o_keep  = r_valid && (r_prio >= i_new.prio);
    assign o_entry = '{valid: r_valid, value: r_value, prio: r_prio};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        unique case (i_op)
            OP_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_valid = 1'b1;
                        n_value = i_new.value;
                        n_prio  = i_new.prio;
                    end else begin
                        n_valid = i_left.valid;
                        n_value = i_left.value;
                        n_prio  = i_left.prio;
                    end
                end
            end
            OP_SHIFT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
                n_prio  = i_right.prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule
